/* hw/rtl/tire_sensor_table_with_aging_assert.svh */
// Assertion macros for the tire-sensor table.
// Used by the top level; needs a clock i_clk and a reset i_rst_n in scope.
`ifndef TIRE_SENSOR_TABLE_WITH_AGING_ASSERT_SVH
`define TIRE_SENSOR_TABLE_WITH_AGING_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSTA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tire sensor table: same-cycle check failed");

// next-cycle implication, checked outside reset
`define TSTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tire sensor table: next-cycle check failed");

`endif

/* hw/rtl/tsta_pkg.sv */
// Shared types, codes and helpers for the tire-sensor table.
// No dependencies; imported by every module of the block except tsta_ram.
`timescale 1ns / 1ps

package tsta_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = TBL_AW + 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int ID_W    = 48;
    localparam int TIME_W  = 40;
    localparam int TMO_W   = 32;
    localparam int ENTRY_W = ID_W + TIME_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // constants of the decode
    localparam logic [4:0]       MIN_FRAME     = 5'd11;
    localparam logic [15:0]      ATM_DECI_PSI  = 16'd146;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd1800000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_ID    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_BOUND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_ID     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_BOUND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;

    // request function codes
    localparam logic FUNC_ADV   = 1'b0;
    localparam logic FUNC_SWEEP = 1'b1;

    // result kind codes
    localparam logic [1:0] KIND_READING = 2'd0;
    localparam logic [1:0] KIND_SHORT   = 2'd1;
    localparam logic [1:0] KIND_SWEEP   = 2'd2;

    // position codes
    localparam logic [1:0] POS_NONE  = 2'd0;
    localparam logic [1:0] POS_FRONT = 2'd1;
    localparam logic [1:0] POS_REAR  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  front_id;
        logic             front_bound;
        logic [ID_W-1:0]  rear_id;
        logic             rear_bound;
        logic [TMO_W-1:0] timeout;
    } t_cfg;

    // command from the request front end to the table walker
    typedef struct packed {
        logic              start;
        logic              sweep;
        logic              walk;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
    } t_scan_cmd;

    // table walker outcome, held until the output stage takes it
    typedef struct packed {
        logic             valid;
        logic             new_device;
        logic             table_full;
        logic [CNT_W-1:0] count;
    } t_scan_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_INSERT,
        S_DONE
    } t_scan_state;

    // stale: stamp not in the future and age strictly above the timeout
    function automatic logic f_is_stale(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] stamp,
                                        input logic [TMO_W-1:0]  tmo);
        logic [TIME_W-1:0] age;
        age = now - stamp;
        return (stamp <= now) && (age > {{(TIME_W-TMO_W){1'b0}}, tmo});
    endfunction

endpackage

/* hw/rtl/tire_sensor_table_with_aging.sv */
// Tire-sensor table top level: request decode, bound-position match, output register.
// A short frame goes straight to the result; a reading or a sweep first walks the table
// (a read of every slot, check of the last slot, a drain step, insert, handoff to the output).
// Throughput: one request at a time; the next is taken only once the result of the last
// has moved into the output register, so a full output register holds it off.
// Reset (synchronous, active low): table empty, count 0, seen times 0, timeout 1800000 ms.
`timescale 1ns / 1ps
`include "tire_sensor_table_with_aging_assert.svh"

module tire_sensor_table_with_aging
    import tsta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [4:0]            i_frame_length,
    input  logic [7:0]            i_sensor_state,
    input  logic [7:0]            i_voltage_raw,
    input  logic [7:0]            i_temp_raw,
    input  logic [15:0]           i_pressure_raw,
    input  logic [ID_W-1:0]       i_sensor_id,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_kind,
    output logic [1:0]            o_position,
    output logic                  o_new_device,
    output logic                  o_table_full,
    output logic signed [7:0]     o_temperature_c,
    output logic [15:0]           o_gauge_pressure,
    output logic [7:0]            o_voltage_dv,
    output logic [7:0]            o_state_out,
    output logic                  o_front_lost,
    output logic                  o_rear_lost,
    output logic [5:0]            o_device_count
);

    t_cfg      w_cfg;
    t_scan_cmd w_cmd;
    t_scan_res w_res;
    logic      w_idle;
    logic      w_accept;
    logic      w_take;
    logic      w_sweep;
    logic      w_long;
    logic      w_reading;
    logic      w_front_hit;
    logic      w_rear_hit;

    // request fields held for the result
    logic [1:0]        r_kind;
    logic [1:0]        r_pos;
    logic [7:0]        r_temp;
    logic [15:0]       r_pres;
    logic [7:0]        r_volt;
    logic [7:0]        r_st;
    logic              r_sweep;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_front_seen;
    logic [TIME_W-1:0] r_rear_seen;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [1:0]  r_out_pos;
    logic        r_out_new;
    logic        r_out_full;
    logic [7:0]  r_out_temp;
    logic [15:0] r_out_pres;
    logic [7:0]  r_out_volt;
    logic [7:0]  r_out_st;
    logic        r_out_front_lost;
    logic        r_out_rear_lost;
    logic [5:0]  r_out_count;

    tsta_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // request decode
    assign o_in_ready  = w_idle;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_sweep     = (i_func == FUNC_SWEEP);
    assign w_long      = (i_frame_length >= MIN_FRAME);
    assign w_reading   = !w_sweep && w_long;
    assign w_front_hit = w_reading && w_cfg.front_bound && (i_sensor_id == w_cfg.front_id);
    assign w_rear_hit  = w_reading && !w_front_hit && w_cfg.rear_bound
                         && (i_sensor_id == w_cfg.rear_id);

    assign w_cmd.start = w_accept;
    assign w_cmd.sweep = w_sweep;
    assign w_cmd.walk  = w_sweep || w_long;
    assign w_cmd.id    = i_sensor_id;
    assign w_cmd.now   = i_now_ms;

    tsta_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .i_take  (w_take),
        .o_idle  (w_idle),
        .o_res   (w_res)
    );

    // capture the decoded reading at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sweep <= w_sweep;
            r_now   <= i_now_ms;
            r_kind  <= w_sweep ? KIND_SWEEP : (w_long ? KIND_READING : KIND_SHORT);
            r_pos   <= w_front_hit ? POS_FRONT : (w_rear_hit ? POS_REAR : POS_NONE);
            r_temp  <= w_reading ? i_temp_raw : 8'd0;
            r_volt  <= w_reading ? i_voltage_raw : 8'd0;
            r_st    <= w_reading ? i_sensor_state : 8'd0;
            r_pres  <= (w_reading && (i_pressure_raw >= ATM_DECI_PSI))
                       ? (i_pressure_raw - ATM_DECI_PSI) : 16'd0;
        end
    end

    // bound-position last-seen times
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_seen <= '0;
            r_rear_seen  <= '0;
        end else if (w_accept) begin
            if (w_front_hit) begin
                r_front_seen <= i_now_ms;
            end
            if (w_rear_hit) begin
                r_rear_seen <= i_now_ms;
            end
        end
    end

    // result moves from the walker into the output register when it is free
    assign w_take = w_res.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_kind       <= r_kind;
            r_out_pos        <= r_pos;
            r_out_new        <= w_res.new_device;
            r_out_full       <= w_res.table_full;
            r_out_temp       <= r_temp;
            r_out_pres       <= r_pres;
            r_out_volt       <= r_volt;
            r_out_st         <= r_st;
            r_out_front_lost <= r_sweep && w_cfg.front_bound
                                && f_is_stale(r_now, r_front_seen, w_cfg.timeout);
            r_out_rear_lost  <= r_sweep && w_cfg.rear_bound
                                && f_is_stale(r_now, r_rear_seen, w_cfg.timeout);
            r_out_count      <= 6'(w_res.count);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_position       = r_out_pos;
    assign o_new_device     = r_out_new;
    assign o_table_full     = r_out_full;
    assign o_temperature_c  = r_out_temp;
    assign o_gauge_pressure = r_out_pres;
    assign o_voltage_dv     = r_out_volt;
    assign o_state_out      = r_out_st;
    assign o_front_lost     = r_out_front_lost;
    assign o_rear_lost      = r_out_rear_lost;
    assign o_device_count   = r_out_count;

    // checks
    `TSTA_ASSERT_NOW(a_no_accept_with_result, w_res.valid, !o_in_ready)
    `TSTA_ASSERT_NOW(a_count_in_range, 1'b1, w_res.count <= CNT_W'(TABLE_DEPTH))
    `TSTA_ASSERT_NEXT(a_idle_after_take, w_take, o_in_ready && o_out_valid)
    `TSTA_ASSERT_NOW(a_full_is_new, o_out_valid && o_table_full, o_new_device)

endmodule

/* hw/rtl/tsta_cfg.sv */
// Configuration registers: bound sensor addresses and the aging timeout.
// Depends on tsta_pkg.
`timescale 1ns / 1ps

module tsta_cfg
    import tsta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the register index; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRONT_ID:    n_cfg.front_id    = i_cfg_data[ID_W-1:0];
                CFG_FRONT_BOUND: n_cfg.front_bound = i_cfg_data[0];
                CFG_REAR_ID:     n_cfg.rear_id     = i_cfg_data[ID_W-1:0];
                CFG_REAR_BOUND:  n_cfg.rear_bound  = i_cfg_data[0];
                CFG_TIMEOUT:     n_cfg.timeout     = i_cfg_data[TMO_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.front_id    <= '0;
            r_cfg.front_bound <= 1'b0;
            r_cfg.rear_id     <= '0;
            r_cfg.rear_bound  <= 1'b0;
            r_cfg.timeout     <= TIMEOUT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/tsta_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tsta_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 88
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tsta_scan.sv */
// Table walker: looks up, inserts, refreshes and ages entries of the sensor table.
// Depends on tsta_pkg and tsta_ram; entry valid bits and the fill count live here.
`timescale 1ns / 1ps

module tsta_scan
    import tsta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_scan_cmd  i_cmd,
    input  logic       i_take,
    output logic       o_idle,
    output t_scan_res  o_res
);

    t_scan_state r_state;
    t_scan_state n_state;

    logic [IDX_W-1:0]       r_rd_idx;
    logic [IDX_W-1:0]       n_rd_idx;
    logic                   r_chk_vld;
    logic                   n_chk_vld;
    logic [TBL_AW-1:0]      r_chk_idx;
    logic [TBL_AW-1:0]      n_chk_idx;
    logic                   r_sweep;
    logic                   n_sweep;
    logic [ID_W-1:0]        r_id;
    logic [ID_W-1:0]        n_id;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      n_now;
    logic                   r_found;
    logic                   n_found;
    logic                   r_have_free;
    logic                   n_have_free;
    logic [TBL_AW-1:0]      r_free_idx;
    logic [TBL_AW-1:0]      n_free_idx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] n_valid;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_new;
    logic                   n_new;
    logic                   r_full;
    logic                   n_full;

    logic                   w_ram_we;
    logic [TBL_AW-1:0]      w_ram_waddr;
    logic                   w_ram_re;
    logic [ENTRY_W-1:0]     w_ram_rdata;
    logic [ID_W-1:0]        w_rd_id;
    logic [TIME_W-1:0]      w_rd_stamp;
    logic                   w_rd_more;
    logic                   w_slot_valid;
    logic                   w_match;
    logic                   w_stale;

    // entry storage: {id, last seen}
    tsta_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata ({r_id, r_now}),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_idx[TBL_AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign w_rd_id      = w_ram_rdata[ENTRY_W-1:TIME_W];
    assign w_rd_stamp   = w_ram_rdata[TIME_W-1:0];
    assign w_rd_more    = r_rd_idx < IDX_W'(TABLE_DEPTH);
    assign w_slot_valid = r_valid[r_chk_idx];
    assign w_match      = w_slot_valid && (w_rd_id == r_id);
    assign w_stale      = f_is_stale(r_now, w_rd_stamp, i_cfg.timeout);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_state = i_cmd.walk ? S_WALK : S_DONE;
                end
            end
            S_WALK: begin
                if (!w_rd_more && !r_chk_vld) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: n_state = S_DONE;
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // walk datapath: read slot i while checking slot i-1
    always_comb begin
        n_rd_idx    = r_rd_idx;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_sweep     = r_sweep;
        n_id        = r_id;
        n_now       = r_now;
        n_found     = r_found;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_valid     = r_valid;
        n_count     = r_count;
        n_new       = r_new;
        n_full      = r_full;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_chk_idx;
        w_ram_re    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_sweep     = i_cmd.sweep;
                    n_id        = i_cmd.id;
                    n_now       = i_cmd.now;
                    n_rd_idx    = '0;
                    n_found     = 1'b0;
                    n_have_free = 1'b0;
                    n_new       = 1'b0;
                    n_full      = 1'b0;
                end
            end
            S_WALK: begin
                if (w_rd_more) begin
                    w_ram_re  = 1'b1;
                    n_rd_idx  = r_rd_idx + IDX_W'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[TBL_AW-1:0];
                end
                if (r_chk_vld) begin
                    if (r_sweep) begin
                        // aging: evict stale entries
                        if (w_slot_valid && w_stale) begin
                            n_valid[r_chk_idx] = 1'b0;
                            n_count            = r_count - CNT_W'(1);
                        end
                    end else if (w_slot_valid) begin
                        // first match gets its time refreshed
                        if (!r_found && w_match) begin
                            w_ram_we = 1'b1;
                            n_found  = 1'b1;
                        end
                    end else if (!r_have_free) begin
                        n_have_free = 1'b1;
                        n_free_idx  = r_chk_idx;
                    end
                end
            end
            S_INSERT: begin
                if (!r_sweep && !r_found) begin
                    n_new = 1'b1;
                    if (r_have_free) begin
                        w_ram_we            = 1'b1;
                        w_ram_waddr         = r_free_idx;
                        n_valid[r_free_idx] = 1'b1;
                        n_count             = r_count + CNT_W'(1);
                    end else begin
                        n_full = 1'b1;
                    end
                end
            end
            S_DONE: begin
                n_chk_vld = 1'b0;
            end
            default: begin
                n_chk_vld = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chk_vld <= 1'b0;
            r_valid   <= '0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= n_chk_vld;
            r_valid   <= n_valid;
            r_count   <= n_count;
        end
    end

    // request context and walk bookkeeping
    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_chk_idx   <= n_chk_idx;
        r_sweep     <= n_sweep;
        r_id        <= n_id;
        r_now       <= n_now;
        r_found     <= n_found;
        r_have_free <= n_have_free;
        r_free_idx  <= n_free_idx;
        r_new       <= n_new;
        r_full      <= n_full;
    end

    assign o_idle           = (r_state == S_IDLE);
    assign o_res.valid      = (r_state == S_DONE);
    assign o_res.new_device = r_new;
    assign o_res.table_full = r_full;
    assign o_res.count      = r_count;

endmodule

/* bench/tb_tire_sensor_table_with_aging.sv */
// Testbench for tire_sensor_table_with_aging: directed and random advertisements and sweeps.
// Needs tsta_pkg and the block's RTL. A scoreboard class predicts every result from its own
// copy of the sensor table and the bound-sensor registers.
`timescale 1ns / 1ps

module tb_tire_sensor_table_with_aging;
    import tsta_pkg::*;

    localparam logic [ID_W-1:0]   ID_ALL_ONES = {ID_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
    localparam logic [ID_W-1:0]   DIR_FRONT   = 48'h0000_1234_5678;
    localparam logic [ID_W-1:0]   DIR_REAR    = 48'hA5A5_0F0F_C3C3;
    localparam int                POOL_SIZE   = 40;
    localparam int                PHASES      = 8;
    localparam int                PHASE_ITEMS = 200;

    // one request as the sender presents it
    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] now_ms;
        logic [4:0]        frame_length;
        logic [7:0]        sensor_state;
        logic [7:0]        voltage_raw;
        logic [7:0]        temp_raw;
        logic [15:0]       pressure_raw;
        logic [ID_W-1:0]   sensor_id;
    } t_adv_req;

    // one result as the block reports it
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  position;
        logic        new_device;
        logic        table_full;
        logic [7:0]  temperature_c;
        logic [15:0] gauge_pressure;
        logic [7:0]  voltage_dv;
        logic [7:0]  state_out;
        logic        front_lost;
        logic        rear_lost;
        logic [5:0]  device_count;
    } t_sensor_report;

    // Sensor table model plus the queue of reports still owed by the block
    class tire_table_scoreboard;
        logic [ID_W-1:0]   front_id;
        logic              front_bound;
        logic [ID_W-1:0]   rear_id;
        logic              rear_bound;
        logic [TMO_W-1:0]  timeout_ms;
        logic [ID_W-1:0]   known_id [TABLE_DEPTH];
        logic [TIME_W-1:0] seen_at [TABLE_DEPTH];
        bit                occupied [TABLE_DEPTH];
        int unsigned       occupancy;
        logic [TIME_W-1:0] front_seen;
        logic [TIME_W-1:0] rear_seen;
        t_sensor_report    owed_q [$];
        int                errors;

        function new();
            front_id    = '0;
            front_bound = 1'b0;
            rear_id     = '0;
            rear_bound  = 1'b0;
            timeout_ms  = TIMEOUT_RESET;
            foreach (occupied[i]) occupied[i] = 1'b0;
            occupancy  = 0;
            front_seen = '0;
            rear_seen  = '0;
            errors     = 0;
        endfunction

        // a stamp in the future has age zero; stale only when strictly older than timeout
        function bit aged_out(logic [TIME_W-1:0] now, logic [TIME_W-1:0] stamp);
            if (stamp > now) return 1'b0;
            return (now - stamp) > {{(TIME_W-TMO_W){1'b0}}, timeout_ms};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRONT_ID:    front_id    = data[ID_W-1:0];
                CFG_FRONT_BOUND: front_bound = data[0];
                CFG_REAR_ID:     rear_id     = data[ID_W-1:0];
                CFG_REAR_BOUND:  rear_bound  = data[0];
                CFG_TIMEOUT:     timeout_ms  = data[TMO_W-1:0];
                default: ;
            endcase
        endfunction

        // update the table for one accepted request and queue the report it owes
        function void note_request(t_adv_req r);
            t_sensor_report rep;
            bit             found;
            bit             have_free;
            int             free_slot;
            rep       = '0;
            found     = 1'b0;
            have_free = 1'b0;
            free_slot = 0;
            if (r.func == FUNC_SWEEP) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (occupied[i] && aged_out(r.now_ms, seen_at[i])) begin
                        occupied[i] = 1'b0;
                        occupancy--;
                    end
                end
                rep.kind       = KIND_SWEEP;
                rep.front_lost = front_bound && aged_out(r.now_ms, front_seen);
                rep.rear_lost  = rear_bound && aged_out(r.now_ms, rear_seen);
            end else if (r.frame_length < MIN_FRAME) begin
                rep.kind = KIND_SHORT;
            end else begin
                // front match wins over rear
                rep.position = POS_NONE;
                if (front_bound && r.sensor_id == front_id) begin
                    rep.position = POS_FRONT;
                    front_seen   = r.now_ms;
                end else if (rear_bound && r.sensor_id == rear_id) begin
                    rep.position = POS_REAR;
                    rear_seen    = r.now_ms;
                end
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (occupied[i]) begin
                        if (!found && known_id[i] == r.sensor_id) begin
                            seen_at[i] = r.now_ms;
                            found      = 1'b1;
                        end
                    end else if (!have_free) begin
                        have_free = 1'b1;
                        free_slot = i;
                    end
                end
                if (!found) begin
                    rep.new_device = 1'b1;
                    if (have_free) begin
                        known_id[free_slot] = r.sensor_id;
                        seen_at[free_slot]  = r.now_ms;
                        occupied[free_slot] = 1'b1;
                        occupancy++;
                    end else begin
                        rep.table_full = 1'b1;
                    end
                end
                rep.kind           = KIND_READING;
                rep.temperature_c  = r.temp_raw;
                rep.gauge_pressure = (r.pressure_raw >= ATM_DECI_PSI) ?
                                     r.pressure_raw - ATM_DECI_PSI : 16'd0;
                rep.voltage_dv     = r.voltage_raw;
                rep.state_out      = r.sensor_state;
            end
            rep.device_count = occupancy[5:0];
            owed_q = {owed_q, rep};
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_report(t_sensor_report got);
            t_sensor_report want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t ns: result expected none actual kind %0d count %0d",
                         $time, got.kind, got.device_count);
                return;
            end
            want = owed_q.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("position", want.position, got.position);
            compare_field("new_device", want.new_device, got.new_device);
            compare_field("table_full", want.table_full, got.table_full);
            compare_field("temperature_c", want.temperature_c, got.temperature_c);
            compare_field("gauge_pressure", want.gauge_pressure, got.gauge_pressure);
            compare_field("voltage_dv", want.voltage_dv, got.voltage_dv);
            compare_field("state_out", want.state_out, got.state_out);
            compare_field("front_lost", want.front_lost, got.front_lost);
            compare_field("rear_lost", want.rear_lost, got.rear_lost);
            compare_field("device_count", want.device_count, got.device_count);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_func;
    logic [TIME_W-1:0]     i_now_ms;
    logic [4:0]            i_frame_length;
    logic [7:0]            i_sensor_state;
    logic [7:0]            i_voltage_raw;
    logic [7:0]            i_temp_raw;
    logic [15:0]           i_pressure_raw;
    logic [ID_W-1:0]       i_sensor_id;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_kind;
    logic [1:0]            o_position;
    logic                  o_new_device;
    logic                  o_table_full;
    logic signed [7:0]     o_temperature_c;
    logic [15:0]           o_gauge_pressure;
    logic [7:0]            o_voltage_dv;
    logic [7:0]            o_state_out;
    logic                  o_front_lost;
    logic                  o_rear_lost;
    logic [5:0]            o_device_count;

    tire_table_scoreboard sb = new();

    logic [TIME_W-1:0] clock_ms;
    logic [ID_W-1:0]   id_pool [POOL_SIZE];
    int                send_quiet;
    int                recv_quiet;

    tire_sensor_table_with_aging u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_now_ms         (i_now_ms),
        .i_frame_length   (i_frame_length),
        .i_sensor_state   (i_sensor_state),
        .i_voltage_raw    (i_voltage_raw),
        .i_temp_raw       (i_temp_raw),
        .i_pressure_raw   (i_pressure_raw),
        .i_sensor_id      (i_sensor_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_position       (o_position),
        .o_new_device     (o_new_device),
        .o_table_full     (o_table_full),
        .o_temperature_c  (o_temperature_c),
        .o_gauge_pressure (o_gauge_pressure),
        .o_voltage_dv     (o_voltage_dv),
        .o_state_out      (o_state_out),
        .o_front_lost     (o_front_lost),
        .o_rear_lost      (o_rear_lost),
        .o_device_count   (o_device_count)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #2_400_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [ID_W-1:0] rand48();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom};
    endfunction

    function automatic logic [TIME_W-1:0] rand40();
        return {8'($urandom_range(0, 8'hFF)), $urandom};
    endfunction

    // draw a random wait before the next item, with occasional stretches of back-to-back traffic
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // all driving tasks start and end at a falling edge
    task automatic send_request(t_adv_req r);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func         = r.func;
        i_now_ms       = r.now_ms;
        i_frame_length = r.frame_length;
        i_sensor_state = r.sensor_state;
        i_voltage_raw  = r.voltage_raw;
        i_temp_raw     = r.temp_raw;
        i_pressure_raw = r.pressure_raw;
        i_sensor_id    = r.sensor_id;
        i_in_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic issue(logic func, logic [TIME_W-1:0] now, logic [4:0] flen,
                         logic [7:0] st, logic [7:0] volt, logic [7:0] temp,
                         logic [15:0] pres, logic [ID_W-1:0] id);
        t_adv_req r;
        r = '{func, now, flen, st, volt, temp, pres, id};
        send_request(r);
    endtask

    // hold off until every owed report has come back, then let the block settle
    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // upper data bits are noise the block must drop
    task automatic program_bindings(logic [ID_W-1:0] fid, logic fb, logic [ID_W-1:0] rid,
                                    logic rb, logic [TMO_W-1:0] tmo);
        write_reg(CFG_FRONT_ID, fid);
        write_reg(CFG_FRONT_BOUND, {47'(rand48()), fb});
        write_reg(CFG_REAR_ID, rid);
        write_reg(CFG_REAR_BOUND, {47'(rand48()), rb});
        write_reg(CFG_TIMEOUT, {16'($urandom_range(0, 16'hFFFF)), tmo});
    endtask

    // random request: mostly advertisements from the pool with time moving forward
    function automatic t_adv_req next_request(int unsigned unit);
        t_adv_req r;
        int       sel;
        r.func = ($urandom_range(0, 7) == 0) ? FUNC_SWEEP : FUNC_ADV;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            clock_ms = rand40();
            r.now_ms = clock_ms;
        end else if (sel == 1) begin
            // stamps later than now
            r.now_ms = clock_ms - TIME_W'($urandom_range(0, unit));
        end else if (sel == 2) begin
            clock_ms = clock_ms + TIME_W'(unit) * TIME_W'($urandom_range(2, 8));
            r.now_ms = clock_ms;
        end else begin
            clock_ms = clock_ms + TIME_W'($urandom_range(0, unit));
            r.now_ms = clock_ms;
        end
        r.frame_length = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 10))
                                                     : 5'($urandom_range(11, 31));
        r.sensor_state = 8'($urandom);
        r.voltage_raw  = 8'($urandom);
        r.temp_raw     = 8'($urandom);
        case ($urandom_range(0, 5))
            0:       r.pressure_raw = 16'($urandom_range(140, 152));
            1:       r.pressure_raw = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: r.pressure_raw = 16'($urandom);
        endcase
        r.sensor_id = ($urandom_range(0, 9) == 0) ? rand48()
                                                  : id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return r;
    endfunction

    // result side: random stalls, sample at the rising edge
    initial begin
        t_sensor_report got;
        int             stall;
        i_out_ready = 1'b0;
        recv_quiet  = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_gap(recv_quiet);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.kind           = o_kind;
            got.position       = o_position;
            got.new_device     = o_new_device;
            got.table_full     = o_table_full;
            got.temperature_c  = o_temperature_c;
            got.gauge_pressure = o_gauge_pressure;
            got.voltage_dv     = o_voltage_dv;
            got.state_out      = o_state_out;
            got.front_lost     = o_front_lost;
            got.rear_lost      = o_rear_lost;
            got.device_count   = o_device_count;
            sb.check_report(got);
            @(negedge i_clk);
        end
    end

    // request side and run control
    initial begin
        logic [ID_W-1:0]  fid;
        logic [ID_W-1:0]  rid;
        logic             fb;
        logic             rb;
        logic [TMO_W-1:0] tmo;
        int unsigned      unit;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_func         = FUNC_ADV;
        i_now_ms       = '0;
        i_frame_length = '0;
        i_sensor_state = '0;
        i_voltage_raw  = '0;
        i_temp_raw     = '0;
        i_pressure_raw = '0;
        i_sensor_id    = '0;
        send_quiet     = 0;
        clock_ms       = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset bindings: sweep on empty table, short frames, field extremes
        issue(FUNC_SWEEP, '0, 5'd0, 8'h00, 8'h00, 8'h00, 16'h0000, '0);
        issue(FUNC_ADV, 40'd100, 5'd0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, ID_ALL_ONES);
        issue(FUNC_ADV, 40'd100, 5'd10, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, ID_ALL_ONES);
        issue(FUNC_ADV, '0, 5'd11, 8'h00, 8'h00, 8'h80, 16'h0000, '0);
        issue(FUNC_ADV, TIME_MAX, 5'd31, 8'hFF, 8'hFF, 8'h7F, 16'hFFFF, ID_ALL_ONES);
        // refresh of a known id; pressure just around atmospheric
        issue(FUNC_ADV, 40'd200, 5'd11, 8'h5A, 8'h21, 8'hFF, 16'd145, '0);
        issue(FUNC_ADV, 40'd300, 5'd20, 8'hA5, 8'h30, 8'h01, 16'd146, '0);
        issue(FUNC_ADV, 40'd400, 5'd20, 8'h3C, 8'h31, 8'h19, 16'd147, 48'h1);
        // evicts the two old entries, keeps the one stamped in the future
        issue(FUNC_SWEEP, 40'd1_900_000, 5'd0, 8'h00, 8'h00, 8'h00, 16'h0000, '0);
        drain();

        program_bindings(DIR_FRONT, 1'b1, DIR_REAR, 1'b1, 32'd1000);
        // bound but never seen: ages from zero
        issue(FUNC_SWEEP, 40'd2000, 5'd0, 8'h00, 8'h00, 8'h00, 16'h0000, '0);
        issue(FUNC_ADV, 40'd5000, 5'd11, 8'h11, 8'h22, 8'h33, 16'd300, DIR_FRONT);
        issue(FUNC_ADV, 40'd5000, 5'd12, 8'h44, 8'h55, 8'hE0, 16'd400, DIR_REAR);
        // age equal to the timeout is not stale, one more is
        issue(FUNC_SWEEP, 40'd6000, 5'd0, 8'h00, 8'h00, 8'h00, 16'h0000, '0);
        issue(FUNC_SWEEP, 40'd6001, 5'd0, 8'h00, 8'h00, 8'h00, 16'h0000, '0);
        issue(FUNC_ADV, 40'd3000, 5'd15, 8'h66, 8'h77, 8'h88, 16'd500, DIR_FRONT);
        issue(FUNC_SWEEP, 40'd2500, 5'd0, 8'h00, 8'h00, 8'h00, 16'h0000, '0);
        drain();

        // same id on both positions: front wins; then unbound front never matches
        write_reg(CFG_REAR_ID, DIR_FRONT);
        write_reg(CFG_TIMEOUT, 48'd1);
        write_reg(CFG_TIMEOUT + 3'd1, rand48());
        issue(FUNC_ADV, 40'd3001, 5'd11, 8'h99, 8'hAA, 8'hBB, 16'd146, DIR_FRONT);
        issue(FUNC_SWEEP, 40'd3003, 5'd0, 8'h00, 8'h00, 8'h00, 16'h0000, '0);
        drain();
        write_reg(CFG_FRONT_BOUND, 48'd0);
        issue(FUNC_ADV, 40'd3004, 5'd11, 8'hCC, 8'hDD, 8'hEE, 16'd147, DIR_FRONT);
        drain();

        // random phases, each with its own bindings and timeout
        for (int p = 0; p < PHASES; p++) begin
            fid = rand48();
            rid = rand48();
            fb  = 1'b1;
            rb  = 1'b1;
            case (p)
                0: begin rb = 1'b0; tmo = 32'd1; end
                1: begin rid = fid; tmo = TIMEOUT_RESET; end
                2: begin fb = 1'b0; tmo = 32'hFFFF_FFFF; end
                3: tmo = 32'($urandom_range(1, 1_000_000));
                4: begin fid = '0; rid = ID_ALL_ONES; tmo = 32'd50; end
                5: begin fb = 1'b0; rb = 1'b0; tmo = $urandom; end
                6: tmo = 32'd1000;
                default: begin fid = ID_ALL_ONES; rid = '0; tmo = TIMEOUT_RESET; end
            endcase
            if (tmo == '0) tmo = 32'd1;
            program_bindings(fid, fb, rid, rb, tmo);
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_TIMEOUT + 3'($urandom_range(1, 3)), rand48());
            foreach (id_pool[i]) id_pool[i] = rand48();
            id_pool[0] = fid;
            id_pool[1] = rid;
            id_pool[2] = '0;
            unit = tmo >> $urandom_range(2, 7);
            if (unit == 0) unit = 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(next_request(unit));
                if ($urandom_range(0, 99) == 0) drain();
            end
            drain();
        end

        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
